// File: hdl/pfa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pfa_pkg;

    localparam int ADDR_W     = 48;
    localparam int PAGES_W    = 11;
    localparam int REF_W      = 16;
    localparam int INDEX_W    = 10;
    localparam int CFG_ADDR_W = 6;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [2:0] {
        CMD_INIT       = 3'd0,
        CMD_ALLOC      = 3'd1,
        CMD_REF_INC    = 3'd2,
        CMD_REF_DEC    = 3'd3,
        CMD_ADDR2FRAME = 3'd4,
        CMD_FRAME2ADDR = 3'd5
    } cmd_t;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FAIL      = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    localparam logic [2:0] REG_R0_BASE   = 3'd0;
    localparam logic [2:0] REG_R0_PAGES  = 3'd1;
    localparam logic [2:0] REG_R1_BASE   = 3'd2;
    localparam logic [2:0] REG_R1_PAGES  = 3'd3;
    localparam logic [2:0] REG_RES_START = 3'd4;
    localparam logic [2:0] REG_RES_END   = 3'd5;

    typedef struct packed {
        logic [ADDR_W-1:0]  r0_base;
        logic [PAGES_W-1:0] r0_pages;
        logic [ADDR_W-1:0]  r1_base;
        logic [PAGES_W-1:0] r1_pages;
        logic [ADDR_W-1:0]  res_start;
        logic [ADDR_W-1:0]  res_end;
    } cfg_t;

    typedef struct packed {
        logic wr_next;
        logic wr_prev;
        logic wr_meta;
    } mem_ctl_t;

endpackage
`default_nettype wire

// File: hdl/page_frame_allocator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Path, accept to m_valid: alloc reads the head frame, unlinks it and loads the result;
// ref inc/dec and frame-to-address read, execute (and push when a decrement frees the
// frame) and load; address-to-frame first finds the region and index (output if not
// found); empty alloc, bad frame or unused command go to output. Init: build all slots,
// reserve-check each in-range slot, unlink removed frames. Throughput: one word at a time.
// Reset (aresetn, synchronous): lists empty, no pages latched; memories are not cleared.
module page_frame_allocator_top #(
    parameter int REGIONS           = 2,
    parameter int FRAMES_PER_REGION = 1024,
    parameter int PAGE_SHIFT        = 12
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [2:0]                       s_cmd,
    input  wire logic [pfa_pkg::ADDR_W-1:0]       s_phys_addr,
    input  wire logic                             s_frame_region,
    input  wire logic [pfa_pkg::INDEX_W-1:0]      s_frame_index,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic      [1:0]                       m_status,
    output logic                                  m_out_region,
    output logic      [pfa_pkg::INDEX_W-1:0]      m_out_index,
    output logic      [pfa_pkg::ADDR_W-1:0]       m_out_addr,
    output logic      [pfa_pkg::REF_W-1:0]        m_ref_after,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [pfa_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [pfa_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic      [pfa_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                                  pready
);

    // frame index width, region select width, link width with a null flag on top
    localparam int IW = $clog2(FRAMES_PER_REGION);
    localparam int RW = (REGIONS > 1) ? $clog2(REGIONS) : 1;
    localparam int LW = IW + 1;
    localparam int AW = RW + IW;

    pfa_pkg::cfg_t             cfg;
    pfa_pkg::mem_ctl_t         mem_ctl;
    logic [AW-1:0]             link_addr, meta_addr, rd_addr;
    logic [LW-1:0]             wr_next, wr_prev, rd_next, rd_prev;
    logic                      wr_on, rd_on;
    logic [pfa_pkg::REF_W-1:0] wr_ref, rd_ref;

    // register file: layout and reserved range, used at the next init
    pfa_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // link memory (next/prev per frame) and meta memory (on-list bit, ref count)
    pfa_mem #(
        .AW (AW),
        .LW (LW)
    ) u_mem (
        .aclk      (aclk),
        .ctl       (mem_ctl),
        .link_addr (link_addr),
        .meta_addr (meta_addr),
        .rd_addr   (rd_addr),
        .wr_next   (wr_next),
        .wr_prev   (wr_prev),
        .wr_on     (wr_on),
        .wr_ref    (wr_ref),
        .rd_next   (rd_next),
        .rd_prev   (rd_prev),
        .rd_on     (rd_on),
        .rd_ref    (rd_ref)
    );

    // sequencer: read, modify, write back one entry per step; holds list heads
    pfa_ctrl #(
        .REGIONS           (REGIONS),
        .FRAMES_PER_REGION (FRAMES_PER_REGION),
        .PAGE_SHIFT        (PAGE_SHIFT),
        .AW                (AW),
        .LW                (LW)
    ) u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_phys_addr    (s_phys_addr),
        .s_frame_region (s_frame_region),
        .s_frame_index  (s_frame_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_out_region   (m_out_region),
        .m_out_index    (m_out_index),
        .m_out_addr     (m_out_addr),
        .m_ref_after    (m_ref_after),
        .mem_ctl        (mem_ctl),
        .link_addr      (link_addr),
        .meta_addr      (meta_addr),
        .rd_addr        (rd_addr),
        .wr_next        (wr_next),
        .wr_prev        (wr_prev),
        .wr_on          (wr_on),
        .wr_ref         (wr_ref),
        .rd_next        (rd_next),
        .rd_prev        (rd_prev),
        .rd_on          (rd_on),
        .rd_ref         (rd_ref)
    );

endmodule
`default_nettype wire

// File: hdl/pfa_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
module pfa_cfg (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [pfa_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [pfa_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic      [pfa_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                                  pready,
    output pfa_pkg::cfg_t                         cfg
);

    pfa_pkg::cfg_t cfg_reg, cfg_next;
    logic [2:0]    reg_idx;
    logic          wr_en;

    assign reg_idx = paddr[5:3];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                pfa_pkg::REG_R0_BASE:   cfg_next.r0_base   = pwdata[pfa_pkg::ADDR_W-1:0];
                pfa_pkg::REG_R0_PAGES:  cfg_next.r0_pages  = pwdata[pfa_pkg::PAGES_W-1:0];
                pfa_pkg::REG_R1_BASE:   cfg_next.r1_base   = pwdata[pfa_pkg::ADDR_W-1:0];
                pfa_pkg::REG_R1_PAGES:  cfg_next.r1_pages  = pwdata[pfa_pkg::PAGES_W-1:0];
                pfa_pkg::REG_RES_START: cfg_next.res_start = pwdata[pfa_pkg::ADDR_W-1:0];
                pfa_pkg::REG_RES_END:   cfg_next.res_end   = pwdata[pfa_pkg::ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            pfa_pkg::REG_R0_BASE:   prdata = pfa_pkg::CFG_DATA_W'(cfg_reg.r0_base);
            pfa_pkg::REG_R0_PAGES:  prdata = pfa_pkg::CFG_DATA_W'(cfg_reg.r0_pages);
            pfa_pkg::REG_R1_BASE:   prdata = pfa_pkg::CFG_DATA_W'(cfg_reg.r1_base);
            pfa_pkg::REG_R1_PAGES:  prdata = pfa_pkg::CFG_DATA_W'(cfg_reg.r1_pages);
            pfa_pkg::REG_RES_START: prdata = pfa_pkg::CFG_DATA_W'(cfg_reg.res_start);
            pfa_pkg::REG_RES_END:   prdata = pfa_pkg::CFG_DATA_W'(cfg_reg.res_end);
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

// File: hdl/pfa_mem.sv
`timescale 1ns / 1ps
`default_nettype none
module pfa_mem #(
    parameter int AW = 11,
    parameter int LW = 11
) (
    input  wire logic                      aclk,
    input  pfa_pkg::mem_ctl_t              ctl,
    input  wire logic [AW-1:0]             link_addr,
    input  wire logic [AW-1:0]             meta_addr,
    input  wire logic [AW-1:0]             rd_addr,
    input  wire logic [LW-1:0]             wr_next,
    input  wire logic [LW-1:0]             wr_prev,
    input  wire logic                      wr_on,
    input  wire logic [pfa_pkg::REF_W-1:0] wr_ref,
    output logic      [LW-1:0]             rd_next,
    output logic      [LW-1:0]             rd_prev,
    output logic                           rd_on,
    output logic      [pfa_pkg::REF_W-1:0] rd_ref
);

    localparam int DEPTH = 1 << AW;

    // link word: next in the upper half, prev in the lower half
    logic [2*LW-1:0]             link_mem [DEPTH];
    logic [pfa_pkg::REF_W:0]     meta_mem [DEPTH];
    logic [2*LW-1:0]             rd_link_reg;
    logic [pfa_pkg::REF_W:0]     rd_meta_reg;

    always_ff @(posedge aclk) begin
        if (ctl.wr_next) begin
            link_mem[link_addr][2*LW-1:LW] <= wr_next;
        end
        if (ctl.wr_prev) begin
            link_mem[link_addr][LW-1:0] <= wr_prev;
        end
        if (ctl.wr_meta) begin
            meta_mem[meta_addr] <= {wr_on, wr_ref};
        end
        rd_link_reg <= link_mem[rd_addr];
        rd_meta_reg <= meta_mem[rd_addr];
    end

    assign rd_next = rd_link_reg[2*LW-1:LW];
    assign rd_prev = rd_link_reg[LW-1:0];
    assign rd_on   = rd_meta_reg[pfa_pkg::REF_W];
    assign rd_ref  = rd_meta_reg[pfa_pkg::REF_W-1:0];

endmodule
`default_nettype wire

// File: hdl/pfa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module pfa_ctrl #(
    parameter int REGIONS           = 2,
    parameter int FRAMES_PER_REGION = 1024,
    parameter int PAGE_SHIFT        = 12,
    parameter int AW                = 11,
    parameter int LW                = 11
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  pfa_pkg::cfg_t                     cfg,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [2:0]                   s_cmd,
    input  wire logic [pfa_pkg::ADDR_W-1:0]   s_phys_addr,
    input  wire logic                         s_frame_region,
    input  wire logic [pfa_pkg::INDEX_W-1:0]  s_frame_index,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic      [1:0]                   m_status,
    output logic                              m_out_region,
    output logic      [pfa_pkg::INDEX_W-1:0]  m_out_index,
    output logic      [pfa_pkg::ADDR_W-1:0]   m_out_addr,
    output logic      [pfa_pkg::REF_W-1:0]    m_ref_after,
    output pfa_pkg::mem_ctl_t                 mem_ctl,
    output logic      [AW-1:0]                link_addr,
    output logic      [AW-1:0]                meta_addr,
    output logic      [AW-1:0]                rd_addr,
    output logic      [LW-1:0]                wr_next,
    output logic      [LW-1:0]                wr_prev,
    output logic                              wr_on,
    output logic      [pfa_pkg::REF_W-1:0]    wr_ref,
    input  wire logic [LW-1:0]                rd_next,
    input  wire logic [LW-1:0]                rd_prev,
    input  wire logic                         rd_on,
    input  wire logic [pfa_pkg::REF_W-1:0]    rd_ref
);

    localparam int IW = LW - 1;
    localparam int RW = AW - IW;
    localparam int PW = IW + 1;
    localparam int EW = pfa_pkg::ADDR_W + 2;
    localparam int AD = pfa_pkg::ADDR_W;
    localparam int PAGES_W_L = pfa_pkg::PAGES_W;
    localparam logic [LW-1:0] NIL = LW'(1) << IW;
    localparam logic [EW-1:0] PG  = EW'(1) << PAGE_SHIFT;
    localparam logic [pfa_pkg::REF_W-1:0] REF_MAX = '1;

    typedef enum logic [13:0] {
        S_IDLE    = 14'b00000000000001,
        S_BUILD   = 14'b00000000000010,
        S_RS_A    = 14'b00000000000100,
        S_RS_X    = 14'b00000000001000,
        S_RS_C    = 14'b00000000010000,
        S_RS_D    = 14'b00000000100000,
        S_UL_W1   = 14'b00000001000000,
        S_UL_W2   = 14'b00000010000000,
        S_LK_REG  = 14'b00000100000000,
        S_LK_IDX  = 14'b00001000000000,
        S_RD      = 14'b00010000000000,
        S_EXEC    = 14'b00100000000000,
        S_PUSH2   = 14'b01000000000000,
        S_OUT     = 14'b10000000000000
    } state_t;

    state_t                       state_reg, state_next;
    pfa_pkg::cmd_t                cmd_reg, cmd_next;
    logic [RW-1:0]                r_reg, r_next;
    logic [IW-1:0]                j_reg, j_next;
    logic [AD-1:0]                pa_reg, pa_next;
    logic [EW-1:0]                a_reg, a_next;
    logic [EW-1:0]                x_reg, x_next;
    logic                         c_pg_reg, c_pg_next;
    logic                         c_end_reg, c_end_next;
    logic [REGIONS-1:0]           match_reg, match_next;
    logic [LW-1:0]                p_reg, p_next;
    logic [LW-1:0]                n_reg, n_next;
    logic [1:0]                   res_status_reg, res_status_next;
    logic                         res_frame_reg, res_frame_next;
    logic [pfa_pkg::REF_W-1:0]    res_ref_reg, res_ref_next;
    logic [AD-1:0]                lay_base_reg [REGIONS];
    logic [AD-1:0]                lay_base_next [REGIONS];
    logic [PW-1:0]                lay_pages_reg [REGIONS];
    logic [PW-1:0]                lay_pages_next [REGIONS];
    logic [EW-1:0]                lay_top_reg [REGIONS];
    logic [EW-1:0]                lay_top_next [REGIONS];
    logic [LW-1:0]                head_reg [REGIONS];
    logic [LW-1:0]                head_next [REGIONS];
    logic                         m_valid_reg, m_valid_next;
    logic [1:0]                   m_status_reg, m_status_next;
    logic                         m_region_reg, m_region_next;
    logic [pfa_pkg::INDEX_W-1:0]  m_index_reg, m_index_next;
    logic [AD-1:0]                m_addr_reg, m_addr_next;
    logic [pfa_pkg::REF_W-1:0]    m_ref_reg, m_ref_next;

    logic                         acc;
    logic [PW-1:0]                cur_pages;
    logic [AD-1:0]                cur_base;
    logic                         j_last, r_last;
    logic [IW-1:0]                j_step;
    logic [RW-1:0]                r_step;
    logic                         fr_ok, fi_ok;
    logic [PW-1:0]                pages_in;
    logic                         alloc_found;
    logic [RW-1:0]                alloc_sel;
    logic                         lk_found;
    logic [RW-1:0]                lk_sel;
    logic                         rs_found;
    logic [RW-1:0]                rs_sel;
    logic [PAGE_SHIFT-1:0]        rs_off;
    logic [EW-1:0]                lk_diff;
    logic [pfa_pkg::REF_W-1:0]    ref_dec;
    logic                         out_load;
    logic [AD-1:0]                raw_base [REGIONS];
    logic [PAGES_W_L-1:0]         raw_pages [REGIONS];

    assign acc       = s_valid && s_ready;
    assign s_ready   = (state_reg == S_IDLE);
    assign cur_pages = lay_pages_reg[r_reg];
    assign cur_base  = lay_base_reg[r_reg];
    assign j_last    = (j_reg == IW'(FRAMES_PER_REGION - 1));
    assign r_last    = (r_reg == RW'(REGIONS - 1));
    assign j_step    = j_last ? '0 : j_reg + 1'b1;
    assign r_step    = j_last ? r_reg + 1'b1 : r_reg;
    assign fr_ok     = (32'(s_frame_region) < REGIONS);
    assign pages_in  = fr_ok ? lay_pages_reg[RW'(s_frame_region)] : '0;
    assign fi_ok     = (32'(s_frame_index) < 32'(pages_in));
    assign rs_off    = cfg.res_start[PAGE_SHIFT-1:0] - a_reg[PAGE_SHIFT-1:0];
    assign lk_diff   = EW'(pa_reg) - EW'(cur_base);
    assign ref_dec   = rd_ref - 1'b1;
    assign out_load  = !m_valid_reg || m_ready;
    assign rd_addr   = {r_reg, j_reg};

    // region sources: base and raw page count per region
    always_comb begin
        for (int i = 0; i < REGIONS; i++) begin
            raw_base[i]  = '0;
            raw_pages[i] = '0;
            if (i == 0) begin
                raw_base[i]  = cfg.r0_base;
                raw_pages[i] = cfg.r0_pages;
            end
            if (i == 1) begin
                raw_base[i]  = cfg.r1_base;
                raw_pages[i] = cfg.r1_pages;
            end
        end
    end

    // first non-empty list, first region holding pa, first region holding x
    always_comb begin
        alloc_found = 1'b0;
        alloc_sel   = '0;
        lk_found    = 1'b0;
        lk_sel      = '0;
        rs_found    = 1'b0;
        rs_sel      = '0;
        for (int i = REGIONS - 1; i >= 0; i--) begin
            if (!head_reg[i][IW]) begin
                alloc_found = 1'b1;
                alloc_sel   = RW'(i);
            end
            if (EW'(pa_reg) >= EW'(lay_base_reg[i]) && EW'(pa_reg) < lay_top_reg[i]) begin
                lk_found = 1'b1;
                lk_sel   = RW'(i);
            end
            if (match_reg[i]) begin
                rs_found = 1'b1;
                rs_sel   = RW'(i);
            end
        end
    end

    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        r_next          = r_reg;
        j_next          = j_reg;
        pa_next         = pa_reg;
        a_next          = a_reg;
        x_next          = x_reg;
        c_pg_next       = c_pg_reg;
        c_end_next      = c_end_reg;
        match_next      = match_reg;
        p_next          = p_reg;
        n_next          = n_reg;
        res_status_next = res_status_reg;
        res_frame_next  = res_frame_reg;
        res_ref_next    = res_ref_reg;
        lay_base_next   = lay_base_reg;
        lay_pages_next  = lay_pages_reg;
        lay_top_next    = lay_top_reg;
        head_next       = head_reg;
        m_valid_next    = m_ready ? 1'b0 : m_valid_reg;
        m_status_next   = m_status_reg;
        m_region_next   = m_region_reg;
        m_index_next    = m_index_reg;
        m_addr_next     = m_addr_reg;
        m_ref_next      = m_ref_reg;
        mem_ctl         = '0;
        link_addr       = {r_reg, j_reg};
        meta_addr       = {r_reg, j_reg};
        wr_next         = NIL;
        wr_prev         = NIL;
        wr_on           = 1'b0;
        wr_ref          = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (acc) begin
                    cmd_next        = pfa_pkg::cmd_t'(s_cmd);
                    pa_next         = s_phys_addr;
                    res_status_next = pfa_pkg::ST_FAIL;
                    res_frame_next  = 1'b0;
                    res_ref_next    = '0;
                    state_next      = S_OUT;
                    case (s_cmd)
                        pfa_pkg::CMD_INIT: begin
                            // latch layout, seed each head with its top frame
                            for (int i = 0; i < REGIONS; i++) begin
                                lay_base_next[i] = raw_base[i];
                                if (32'(raw_pages[i]) > 32'(FRAMES_PER_REGION)) begin
                                    lay_pages_next[i] = PW'(FRAMES_PER_REGION);
                                end else begin
                                    lay_pages_next[i] = PW'(raw_pages[i]);
                                end
                                lay_top_next[i] = EW'(raw_base[i])
                                                + (EW'(lay_pages_next[i]) << PAGE_SHIFT);
                                head_next[i] = (lay_pages_next[i] == '0) ? NIL
                                             : LW'(lay_pages_next[i] - 1'b1);
                            end
                            res_status_next = pfa_pkg::ST_OK;
                            r_next          = '0;
                            j_next          = '0;
                            state_next      = S_BUILD;
                        end
                        pfa_pkg::CMD_ALLOC: begin
                            if (alloc_found) begin
                                r_next     = alloc_sel;
                                j_next     = head_reg[alloc_sel][IW-1:0];
                                state_next = S_RD;
                            end
                        end
                        pfa_pkg::CMD_REF_INC, pfa_pkg::CMD_REF_DEC,
                        pfa_pkg::CMD_FRAME2ADDR: begin
                            if (fr_ok && fi_ok) begin
                                r_next     = RW'(s_frame_region);
                                j_next     = IW'(s_frame_index);
                                state_next = S_RD;
                            end
                        end
                        pfa_pkg::CMD_ADDR2FRAME: state_next = S_LK_REG;
                        default: ;
                    endcase
                end
            end
            S_BUILD: begin
                // chain frames downward: next is j-1, prev is j+1
                mem_ctl.wr_next = 1'b1;
                mem_ctl.wr_prev = 1'b1;
                mem_ctl.wr_meta = 1'b1;
                wr_next = (j_reg == '0) ? NIL : LW'(j_reg - 1'b1);
                wr_prev = (PW'(j_reg) + 1'b1 == cur_pages) ? NIL : LW'(j_reg) + 1'b1;
                wr_on   = (PW'(j_reg) < cur_pages);
                wr_ref  = '0;
                if (j_last && r_last) begin
                    r_next     = '0;
                    j_next     = '0;
                    state_next = S_RS_A;
                end else begin
                    r_next = r_step;
                    j_next = j_step;
                end
            end
            S_RS_A: begin
                if (PW'(j_reg) < cur_pages) begin
                    a_next     = EW'(cur_base) + (EW'(j_reg) << PAGE_SHIFT);
                    state_next = S_RS_X;
                end else if (j_last && r_last) begin
                    state_next = S_OUT;
                end else begin
                    r_next = r_step;
                    j_next = j_step;
                end
            end
            S_RS_X: begin
                // first reserved address at or above the frame start
                if (a_reg >= EW'(cfg.res_start)) begin
                    x_next = a_reg + EW'(rs_off);
                end else begin
                    x_next = EW'(cfg.res_start);
                end
                state_next = S_RS_C;
            end
            S_RS_C: begin
                c_pg_next  = (x_reg < a_reg + PG);
                c_end_next = (x_reg < EW'(cfg.res_end));
                for (int i = 0; i < REGIONS; i++) begin
                    match_next[i] = (x_reg >= EW'(lay_base_reg[i])) && (x_reg < lay_top_reg[i]);
                end
                state_next = S_RS_D;
            end
            S_RS_D: begin
                if (c_pg_reg && c_end_reg && rs_found && rs_sel == r_reg) begin
                    state_next = S_UL_W1;
                end else if (j_last && r_last) begin
                    state_next = S_OUT;
                end else begin
                    r_next     = r_step;
                    j_next     = j_step;
                    state_next = S_RS_A;
                end
            end
            S_UL_W1: begin
                p_next = rd_prev;
                n_next = rd_next;
                if (cmd_reg == pfa_pkg::CMD_ALLOC) begin
                    res_status_next = pfa_pkg::ST_OK;
                    res_frame_next  = 1'b1;
                    res_ref_next    = rd_ref;
                end
                if (rd_on) begin
                    mem_ctl.wr_meta = 1'b1;
                    wr_on           = 1'b0;
                    wr_ref          = rd_ref;
                    if (!rd_prev[IW]) begin
                        mem_ctl.wr_next = 1'b1;
                        link_addr       = {r_reg, rd_prev[IW-1:0]};
                        wr_next         = rd_next;
                    end else begin
                        head_next[r_reg] = rd_next;
                    end
                    state_next = S_UL_W2;
                end else if (cmd_reg != pfa_pkg::CMD_INIT) begin
                    state_next = S_OUT;
                end else if (j_last && r_last) begin
                    state_next = S_OUT;
                end else begin
                    r_next     = r_step;
                    j_next     = j_step;
                    state_next = S_RS_A;
                end
            end
            S_UL_W2: begin
                if (!n_reg[IW]) begin
                    mem_ctl.wr_prev = 1'b1;
                    link_addr       = {r_reg, n_reg[IW-1:0]};
                    wr_prev         = p_reg;
                end
                if (cmd_reg != pfa_pkg::CMD_INIT) begin
                    state_next = S_OUT;
                end else if (j_last && r_last) begin
                    state_next = S_OUT;
                end else begin
                    r_next     = r_step;
                    j_next     = j_step;
                    state_next = S_RS_A;
                end
            end
            S_LK_REG: begin
                if (lk_found) begin
                    r_next     = lk_sel;
                    state_next = S_LK_IDX;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_LK_IDX: begin
                j_next     = IW'(lk_diff >> PAGE_SHIFT);
                state_next = S_RD;
            end
            S_RD: begin
                state_next = (cmd_reg == pfa_pkg::CMD_ALLOC) ? S_UL_W1 : S_EXEC;
            end
            S_EXEC: begin
                res_status_next = pfa_pkg::ST_OK;
                res_frame_next  = 1'b1;
                res_ref_next    = rd_ref;
                state_next      = S_OUT;
                case (cmd_reg)
                    pfa_pkg::CMD_REF_INC: begin
                        mem_ctl.wr_meta = 1'b1;
                        wr_on           = rd_on;
                        wr_ref          = (rd_ref == REF_MAX) ? rd_ref : rd_ref + 1'b1;
                        res_ref_next    = wr_ref;
                    end
                    pfa_pkg::CMD_REF_DEC: begin
                        if (rd_ref == '0) begin
                            res_status_next = pfa_pkg::ST_UNDERFLOW;
                        end else begin
                            mem_ctl.wr_meta = 1'b1;
                            wr_on           = rd_on;
                            wr_ref          = ref_dec;
                            res_ref_next    = ref_dec;
                            if (ref_dec == '0 && !rd_on) begin
                                // push onto the head of its region's list
                                mem_ctl.wr_next  = 1'b1;
                                mem_ctl.wr_prev  = 1'b1;
                                wr_next          = head_reg[r_reg];
                                wr_prev          = NIL;
                                wr_on            = 1'b1;
                                n_next           = head_reg[r_reg];
                                head_next[r_reg] = LW'(j_reg);
                                state_next       = S_PUSH2;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            S_PUSH2: begin
                if (!n_reg[IW]) begin
                    mem_ctl.wr_prev = 1'b1;
                    link_addr       = {r_reg, n_reg[IW-1:0]};
                    wr_prev         = LW'(j_reg);
                end
                state_next = S_OUT;
            end
            S_OUT: begin
                if (out_load) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    if (res_frame_reg) begin
                        m_region_next = 1'(r_reg);
                        m_index_next  = pfa_pkg::INDEX_W'(j_reg);
                        m_addr_next   = AD'(EW'(cur_base) + (EW'(j_reg) << PAGE_SHIFT));
                        m_ref_next    = res_ref_reg;
                    end else begin
                        m_region_next = 1'b0;
                        m_index_next  = '0;
                        m_addr_next   = '0;
                        m_ref_next    = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            m_valid_reg   <= 1'b0;
            for (int i = 0; i < REGIONS; i++) begin
                lay_base_reg[i]  <= '0;
                lay_pages_reg[i] <= '0;
                lay_top_reg[i]   <= '0;
                head_reg[i]      <= NIL;
            end
        end else begin
            state_reg     <= state_next;
            m_valid_reg   <= m_valid_next;
            lay_base_reg  <= lay_base_next;
            lay_pages_reg <= lay_pages_next;
            lay_top_reg   <= lay_top_next;
            head_reg      <= head_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        r_reg          <= r_next;
        j_reg          <= j_next;
        pa_reg         <= pa_next;
        a_reg          <= a_next;
        x_reg          <= x_next;
        c_pg_reg       <= c_pg_next;
        c_end_reg      <= c_end_next;
        match_reg      <= match_next;
        p_reg          <= p_next;
        n_reg          <= n_next;
        res_status_reg <= res_status_next;
        res_frame_reg  <= res_frame_next;
        res_ref_reg    <= res_ref_next;
        m_status_reg   <= m_status_next;
        m_region_reg   <= m_region_next;
        m_index_reg    <= m_index_next;
        m_addr_reg     <= m_addr_next;
        m_ref_reg      <= m_ref_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_out_region = m_region_reg;
    assign m_out_index  = m_index_reg;
    assign m_out_addr   = m_addr_reg;
    assign m_ref_after  = m_ref_reg;

    a_out_from_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result word loaded outside the output step");

    a_idle_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> (mem_ctl == '0))
        else $error("memory written while idle");

    a_init_builds: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc && s_cmd == pfa_pkg::CMD_INIT) |=> (state_reg == S_BUILD))
        else $error("init did not start the build sweep");

    a_head_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        !head_reg[0][IW] |-> ({1'b0, head_reg[0][IW-1:0]} < lay_pages_reg[0]))
        else $error("region 0 head points past its page count");

endmodule
`default_nettype wire

// File: sim/page_frame_allocator_checker.sv
`timescale 1ns / 1ps
module page_frame_allocator_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    input  logic                             s_ready,
    input  logic [2:0]                       s_cmd,
    input  logic [pfa_pkg::ADDR_W-1:0]       s_phys_addr,
    input  logic                             s_frame_region,
    input  logic [pfa_pkg::INDEX_W-1:0]      s_frame_index,
    input  logic                             m_valid,
    input  logic                             m_ready,
    input  logic [1:0]                       m_status,
    input  logic                             m_out_region,
    input  logic [pfa_pkg::INDEX_W-1:0]      m_out_index,
    input  logic [pfa_pkg::ADDR_W-1:0]       m_out_addr,
    input  logic [pfa_pkg::REF_W-1:0]        m_ref_after,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic                             pready,
    input  logic [pfa_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [pfa_pkg::CFG_DATA_W-1:0]   pwdata,
    output int                               fail_count,
    output int                               outstanding
);

    localparam int NREG   = 2;
    localparam int NFRAME = 1024;
    localparam int PSHIFT = 12;
    localparam int NIL    = -1;
    localparam int AW_L   = pfa_pkg::ADDR_W;
    localparam int IW_L   = pfa_pkg::INDEX_W;

    typedef struct {
        logic [1:0]                 status;
        logic                       region;
        logic [IW_L-1:0]            index;
        logic [AW_L-1:0]            addr;
        logic [pfa_pkg::REF_W-1:0]  refs;
    } frame_result_t;

    frame_result_t result_q[$];

    // register shadows, latched into the layout by init
    logic [63:0] sh_base [NREG];
    int          sh_pages[NREG];
    logic [63:0] sh_res_start, sh_res_end;

    logic [63:0] lay_base [NREG];
    int          lay_pages[NREG];
    int          link_next[NREG][NFRAME];
    int          link_prev[NREG][NFRAME];
    int          free_head[NREG];
    bit          on_free  [NREG][NFRAME];
    logic [15:0] refcnt   [NREG][NFRAME];

    function automatic void free_push(int r, int j);
        int h;
        h = free_head[r];
        if (on_free[r][j]) return;
        link_next[r][j] = h;
        link_prev[r][j] = NIL;
        if (h != NIL) link_prev[r][h] = j;
        free_head[r] = j;
        on_free[r][j] = 1;
    endfunction

    function automatic void free_unlink(int r, int j);
        int p, n;
        if (!on_free[r][j]) return;
        p = link_prev[r][j];
        n = link_next[r][j];
        if (p != NIL) link_next[r][p] = n;
        else free_head[r] = n;
        if (n != NIL) link_prev[r][n] = p;
        on_free[r][j] = 0;
    endfunction

    function automatic int owner_region(logic [63:0] x);
        logic [63:0] top;
        for (int r = 0; r < NREG; r++) begin
            top = lay_base[r] + (64'(lay_pages[r]) << PSHIFT);
            if (x >= lay_base[r] && x < top) return r;
        end
        return NREG;
    endfunction

    function automatic logic [AW_L-1:0] page_addr(int r, int j);
        logic [63:0] a;
        a = lay_base[r] + (64'(j) << PSHIFT);
        return a[AW_L-1:0];
    endfunction

    function automatic void rebuild_free_lists();
        logic [63:0] a, x, k, pg;
        pg = 64'd1 << PSHIFT;
        for (int r = 0; r < NREG; r++) begin
            lay_base[r]  = sh_base[r];
            lay_pages[r] = (sh_pages[r] > NFRAME) ? NFRAME : sh_pages[r];
            free_head[r] = NIL;
            for (int j = 0; j < NFRAME; j++) begin
                refcnt[r][j]  = '0;
                on_free[r][j] = 0;
            end
            for (int j = 0; j < lay_pages[r]; j++) free_push(r, j);
        end
        // drop every frame that a reserved page address lands in, unless a lower region owns it
        for (int r = 0; r < NREG; r++) begin
            for (int j = 0; j < lay_pages[r]; j++) begin
                a = lay_base[r] + (64'(j) << PSHIFT);
                if (a >= sh_res_start) begin
                    k = (a - sh_res_start + pg - 1) >> PSHIFT;
                    x = sh_res_start + (k << PSHIFT);
                end else begin
                    x = sh_res_start;
                end
                if (x >= a + pg || x >= sh_res_end) continue;
                if (owner_region(x) == r) free_unlink(r, j);
            end
        end
    endfunction

    function automatic frame_result_t predict_frame_op(logic [2:0] c, logic [AW_L-1:0] pa,
                                                       logic fr, logic [IW_L-1:0] fi);
        frame_result_t res;
        bit ok_frame;
        int r, j;
        res = '{pfa_pkg::ST_FAIL, 1'b0, '0, '0, '0};
        ok_frame = int'(fi) < lay_pages[fr];
        case (c)
            pfa_pkg::CMD_INIT: begin
                rebuild_free_lists();
                res.status = pfa_pkg::ST_OK;
            end
            pfa_pkg::CMD_ALLOC: begin
                for (r = 0; r < NREG; r++) begin
                    j = free_head[r];
                    if (j != NIL) begin
                        free_unlink(r, j);
                        res = '{pfa_pkg::ST_OK, r[0], j[IW_L-1:0], page_addr(r, j),
                                refcnt[r][j]};
                        break;
                    end
                end
            end
            pfa_pkg::CMD_REF_INC: if (ok_frame) begin
                if (refcnt[fr][fi] != 16'hFFFF) refcnt[fr][fi]++;
                res = '{pfa_pkg::ST_OK, fr, fi, page_addr(fr, fi), refcnt[fr][fi]};
            end
            pfa_pkg::CMD_REF_DEC: if (ok_frame) begin
                if (refcnt[fr][fi] == 0) begin
                    res.status = pfa_pkg::ST_UNDERFLOW;
                end else begin
                    refcnt[fr][fi]--;
                    if (refcnt[fr][fi] == 0) free_push(fr, fi);
                    res.status = pfa_pkg::ST_OK;
                end
                res.region = fr;
                res.index  = fi;
                res.addr   = page_addr(fr, fi);
                res.refs   = refcnt[fr][fi];
            end
            pfa_pkg::CMD_ADDR2FRAME: begin
                r = owner_region(64'(pa));
                if (r < NREG) begin
                    j = int'((64'(pa) - lay_base[r]) >> PSHIFT);
                    res = '{pfa_pkg::ST_OK, r[0], j[IW_L-1:0], page_addr(r, j),
                            refcnt[r][j]};
                end
            end
            pfa_pkg::CMD_FRAME2ADDR: if (ok_frame)
                res = '{pfa_pkg::ST_OK, fr, fi, page_addr(fr, fi), refcnt[fr][fi]};
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge aclk) begin
        frame_result_t want;
        if (!aresetn) begin
            fail_count   = 0;
            result_q.delete();
            sh_res_start = '0;
            sh_res_end   = '0;
            for (int r = 0; r < NREG; r++) begin
                sh_base[r]   = '0;
                sh_pages[r]  = 0;
                lay_base[r]  = '0;
                lay_pages[r] = 0;
                free_head[r] = NIL;
                for (int j = 0; j < NFRAME; j++) begin
                    refcnt[r][j]  = '0;
                    on_free[r][j] = 0;
                end
            end
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[5:3])
                    pfa_pkg::REG_R0_BASE:   sh_base[0]   = {16'd0, pwdata[AW_L-1:0]};
                    pfa_pkg::REG_R0_PAGES:  sh_pages[0]  = int'(pwdata[pfa_pkg::PAGES_W-1:0]);
                    pfa_pkg::REG_R1_BASE:   sh_base[1]   = {16'd0, pwdata[AW_L-1:0]};
                    pfa_pkg::REG_R1_PAGES:  sh_pages[1]  = int'(pwdata[pfa_pkg::PAGES_W-1:0]);
                    pfa_pkg::REG_RES_START: sh_res_start = {16'd0, pwdata[AW_L-1:0]};
                    pfa_pkg::REG_RES_END:   sh_res_end   = {16'd0, pwdata[AW_L-1:0]};
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (result_q.size() == 0) begin
                    $error("result word with no command pending");
                    fail_count++;
                end else begin
                    want = result_q.pop_front();
                    if (m_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_status);
                        fail_count++;
                    end
                    if (m_out_region !== want.region) begin
                        $error("out_region: expected %0d, got %0d", want.region, m_out_region);
                        fail_count++;
                    end
                    if (m_out_index !== want.index) begin
                        $error("out_index: expected %0d, got %0d", want.index, m_out_index);
                        fail_count++;
                    end
                    if (m_out_addr !== want.addr) begin
                        $error("out_addr: expected %h, got %h", want.addr, m_out_addr);
                        fail_count++;
                    end
                    if (m_ref_after !== want.refs) begin
                        $error("ref_after: expected %0d, got %0d", want.refs, m_ref_after);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready)
                result_q.push_back(predict_frame_op(s_cmd, s_phys_addr, s_frame_region,
                                                    s_frame_index));
        end
        outstanding = result_q.size();
    end

endmodule

// File: sim/page_frame_allocator_top_tb.sv
`timescale 1ns / 1ps
module page_frame_allocator_top_tb;

    // cycles with no accepted word before the run is called hung; a full
    // two-region init with every frame reserved stays well below this
    localparam int STALL_LIMIT = 60000;
    localparam logic [47:0] ADDR_MAX = 48'hFFFF_FFFF_FFFF;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                                s_valid = 1'b0;
    logic                                s_ready;
    logic [2:0]                          s_cmd = pfa_pkg::CMD_INIT;
    logic [pfa_pkg::ADDR_W-1:0]          s_phys_addr = '0;
    logic                                s_frame_region = 1'b0;
    logic [pfa_pkg::INDEX_W-1:0]         s_frame_index = '0;
    logic                                m_valid;
    logic                                m_ready = 1'b0;
    logic [1:0]                          m_status;
    logic                                m_out_region;
    logic [pfa_pkg::INDEX_W-1:0]         m_out_index;
    logic [pfa_pkg::ADDR_W-1:0]          m_out_addr;
    logic [pfa_pkg::REF_W-1:0]           m_ref_after;
    logic                                psel = 1'b0;
    logic                                penable = 1'b0;
    logic                                pwrite = 1'b0;
    logic [pfa_pkg::CFG_ADDR_W-1:0]      paddr = '0;
    logic [pfa_pkg::CFG_DATA_W-1:0]      pwdata = '0;
    logic [pfa_pkg::CFG_DATA_W-1:0]      prdata;
    logic                                pready;

    int fail_count;
    int outstanding;
    int idle_cycles = 0;
    bit steady = 0;              // set: no gaps or stalls on either side

    // layout as written, and as latched by the last init sent
    logic [63:0] wr_base[2], lat_base[2];
    int          wr_pages[2], lat_pages[2];

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    page_frame_allocator_top dut (
        .aclk, .aresetn,
        .s_valid, .s_ready, .s_cmd, .s_phys_addr, .s_frame_region, .s_frame_index,
        .m_valid, .m_ready, .m_status, .m_out_region, .m_out_index, .m_out_addr,
        .m_ref_after,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    page_frame_allocator_checker u_checker (
        .aclk, .aresetn,
        .s_valid, .s_ready, .s_cmd, .s_phys_addr, .s_frame_region, .s_frame_index,
        .m_valid, .m_ready, .m_status, .m_out_region, .m_out_index, .m_out_addr,
        .m_ref_after,
        .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
        .fail_count, .outstanding
    );

    // Mostly short gaps, now and then a long one; none while steady.
    function automatic int gap_len();
        int p;
        if (steady) return 0;
        p = $urandom_range(99);
        if (p < 60) return 0;
        if (p < 90) return $urandom_range(3, 1);
        if (p < 98) return $urandom_range(10, 4);
        return $urandom_range(80, 20);
    endfunction

    // Result side: hold m_ready low for random stretches.
    always @(negedge aclk) begin
        int hold;
        if (hold > 0) begin
            hold--;
            m_ready <= 1'b0;
        end else begin
            hold = gap_len();
            m_ready <= (hold == 0);
        end
    end

    // Hang detector: count cycles in which no word moves on any port.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Send one command word; enter and leave on a falling edge.
    task automatic send_word(logic [2:0] c, logic [47:0] pa, logic fr, logic [9:0] fi);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_cmd          <= c;
        s_phys_addr    <= pa;
        s_frame_region <= fr;
        s_frame_index  <= fi;
        if (c == pfa_pkg::CMD_INIT) begin
            for (int r = 0; r < 2; r++) begin
                lat_base[r]  = wr_base[r];
                lat_pages[r] = (wr_pages[r] > 1024) ? 1024 : wr_pages[r];
            end
        end
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Drain every pending result and let the block settle before a register write.
    task automatic drain();
        s_valid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task automatic reg_write(logic [2:0] idx, logic [63:0] val);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_layout(logic [63:0] b0, int p0, logic [63:0] b1, int p1,
                               logic [63:0] rs, logic [63:0] re);
        drain();
        reg_write(pfa_pkg::REG_R0_BASE, b0);
        reg_write(pfa_pkg::REG_R0_PAGES, 64'(p0));
        reg_write(pfa_pkg::REG_R1_BASE, b1);
        reg_write(pfa_pkg::REG_R1_PAGES, 64'(p1));
        reg_write(pfa_pkg::REG_RES_START, rs);
        reg_write(pfa_pkg::REG_RES_END, re);
        wr_base[0] = b0;
        wr_pages[0] = p0;
        wr_base[1] = b1;
        wr_pages[1] = p1;
        send_word(pfa_pkg::CMD_INIT, '0, 1'b0, '0);
    endtask

    function automatic logic [47:0] rand_addr();
        return {$urandom, $urandom};
    endfunction

    // Random command with a mostly well-formed frame or address, some noise.
    task automatic send_random();
        int p, r;
        logic [2:0] c;
        logic [47:0] pa;
        logic [9:0] fi;
        logic [63:0] span;
        p = $urandom_range(999);
        if (p < 8)        c = pfa_pkg::CMD_INIT;
        else if (p < 260) c = pfa_pkg::CMD_ALLOC;
        else if (p < 470) c = pfa_pkg::CMD_REF_INC;
        else if (p < 720) c = pfa_pkg::CMD_REF_DEC;
        else if (p < 850) c = pfa_pkg::CMD_ADDR2FRAME;
        else if (p < 980) c = pfa_pkg::CMD_FRAME2ADDR;
        else              c = 3'($urandom_range(7, 6));
        r  = $urandom_range(1);
        fi = 10'($urandom);
        pa = rand_addr();
        if ($urandom_range(99) < 85 && lat_pages[r] > 0) begin
            fi   = 10'($urandom_range(lat_pages[r] - 1));
            span = 64'(lat_pages[r]) << 12;
            pa   = 48'(lat_base[r] + ({$urandom, $urandom} % span));
        end
        send_word(c, pa, r[0], fi);
    endtask

    initial begin
        for (int r = 0; r < 2; r++) begin
            wr_base[r] = '0;
            wr_pages[r] = 0;
            lat_base[r] = '0;
            lat_pages[r] = 0;
        end
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Before any init no frame is valid and the lists are empty.
        send_word(pfa_pkg::CMD_ALLOC, '0, 1'b0, '0);
        send_word(pfa_pkg::CMD_REF_INC, '0, 1'b0, '0);
        send_word(pfa_pkg::CMD_ADDR2FRAME, '0, 1'b0, '0);
        send_word(3'd6, ADDR_MAX, 1'b1, 10'h3FF);
        send_word(3'd7, '0, 1'b0, '0);

        // Small layout with a reserved range cutting into region 0.
        load_layout(64'h1000_0000, 8, 64'h2000_0000, 4, 64'h1000_2800, 64'h1000_5000);
        repeat (13) send_word(pfa_pkg::CMD_ALLOC, '0, 1'b0, '0);  // drain both, then fail
        send_word(pfa_pkg::CMD_REF_INC, '0, 1'b0, 10'd7);
        send_word(pfa_pkg::CMD_REF_DEC, '0, 1'b0, 10'd7);         // back to zero: push
        send_word(pfa_pkg::CMD_REF_DEC, '0, 1'b0, 10'd7);         // underflow
        send_word(pfa_pkg::CMD_REF_DEC, '0, 1'b1, 10'd4);         // index past page count
        send_word(pfa_pkg::CMD_ADDR2FRAME, 48'h1000_7FFF, 1'b0, '0);
        send_word(pfa_pkg::CMD_ADDR2FRAME, 48'h2000_4000, 1'b0, '0);  // just past region 1
        send_word(pfa_pkg::CMD_FRAME2ADDR, '0, 1'b1, 10'd3);

        // Extremes: clamped page count, region past the top of the address space,
        // reserve range covering everything, unused region 1.
        load_layout({16'd0, ADDR_MAX} - 64'hFFF, 2047, {16'd0, ADDR_MAX}, 0, 0,
                    {16'd0, ADDR_MAX});
        send_word(pfa_pkg::CMD_ALLOC, '0, 1'b0, '0);
        send_word(pfa_pkg::CMD_FRAME2ADDR, '0, 1'b0, 10'h3FF);
        send_word(pfa_pkg::CMD_ADDR2FRAME, ADDR_MAX, 1'b0, '0);
        repeat (40) send_random();

        // Full overlapping regions; run a reference count up back to back.
        load_layout(0, 1024, 64'h20_0000, 1024, 64'h1000, 64'h5000);
        steady = 1;
        repeat (200) send_word(pfa_pkg::CMD_REF_INC, '0, 1'b0, 10'd600);
        send_word(pfa_pkg::CMD_REF_DEC, '0, 1'b0, 10'd600);
        steady = 0;
        repeat (300) send_random();

        // Random layouts, mostly small so that inits stay short.
        for (int ph = 0; ph < 5; ph++) begin
            logic [63:0] b0, b1, rs;
            int p0, p1;
            b0 = {16'd0, rand_addr()} & 64'hFFFF_FFFF_F000;
            b1 = (ph == 2) ? b0 + 64'h4000 : ({16'd0, rand_addr()} & 64'hFFFF_FFFF_F000);
            p0 = (ph == 4) ? 1024 : $urandom_range(16, 0);
            p1 = $urandom_range(16, 1);
            rs = b0 + 64'($urandom_range(p0 * 4096 + 4096));
            load_layout(b0, p0, b1, p1, rs, rs + 64'($urandom_range(6 * 4096)));
            steady = (ph == 1);
            repeat (240) send_random();
            steady = 0;
        end

        s_valid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (30) @(posedge aclk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: sim.f
hdl/pfa_pkg.sv
hdl/pfa_cfg.sv
hdl/pfa_mem.sv
hdl/pfa_ctrl.sv
hdl/page_frame_allocator_top.sv
sim/page_frame_allocator_checker.sv
sim/page_frame_allocator_top_tb.sv
